// ===== rtl/ffbb_pkg.sv =====
package ffbb_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Input item operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SEED = 1'b1;

    // Neighbor order: up, down, left, right
    localparam int DIR_W = 2;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    localparam int          CFG_W     = 9;
    localparam logic [8:0]  IMG_RESET = 9'd256;
    // Width used for all bound compares (covers 4096 and the 9-bit registers)
    localparam int          CMP_W     = 17;
    // Width of the per-run visited tag
    localparam int          EPOCH_W   = 4;

    typedef struct packed {
        logic               op;
        logic               opaque;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [7:0] box_x;
        logic [7:0] box_y;
        logic [8:0] box_width;
        logic [8:0] box_height;
    } t_out_item;

    typedef struct packed {
        t_cfg_idx         index;
        logic [CFG_W-1:0] value;
    } t_cfg_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load_wr;
        logic seed_cap;
        logic seed_eval;
        logic clr_step;
        logic run_init;
        logic pop;
        logic cur_cap;
        logic nbr_skip;
        logic nbr_chk;
        logic res_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic seed_ok;
        logic epoch_full;
        logic clr_last;
        logic q_empty;
        logic nbr_in;
        logic k_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/ffbb_stream_if.sv =====
interface ffbb_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/flood_fill_bounding_box.sv =====
// Channel   Modport  Payload                                      Transaction
// i_in      sink     op, opaque, coord_x, coord_y                 load a pixel / seed a fill
// o_out     source   found, box_x, box_y, box_width, box_height   one per seed
// i_cfg     sink     index, value                                 image_width / image_height
//
// Loads are taken one per cycle, back to back, while no seed is in progress. A
// found seed reads its pixel, then pops each cell of the region and reads and
// checks each neighbor inside the map; a missed seed goes straight to its answer.
// All of it is bound by the single memory ports. Every 15th fill first sweeps
// the visited tags of the map, MAX_WIDTH by MAX_HEIGHT each rounded up to a
// power of two, as does the first fill after reset. Reset is synchronous, active
// low; a waiting result holds the next seed's answer and input after it, not its fill.
module flood_fill_bounding_box #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ffbb_stream_if.sink          i_in,
    ffbb_stream_if.source        o_out,
    ffbb_stream_if.sink          i_cfg
);
    import ffbb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ffbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.data.op),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffbb_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data),
        .i_out_ready (o_out.ready),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_cfg_ready (i_cfg.ready),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );
endmodule

// ===== rtl/ffbb_ram.sv =====
module ffbb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/ffbb_ctrl.sv =====
module ffbb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    output logic          o_in_ready,
    input  ffbb_pkg::t_sts i_sts,
    output ffbb_pkg::t_cmd o_cmd
);
    import ffbb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SEED = 9'b000000010,
        S_CLR  = 9'b000000100,
        S_INIT = 9'b000001000,
        S_POP  = 9'b000010000,
        S_CUR  = 9'b000100000,
        S_NREQ = 9'b001000000,
        S_NCHK = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_SEED) begin
                        o_cmd.seed_cap = 1'b1;
                        n_state        = S_SEED;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_SEED: begin
                // opacity of the seed pixel is on the read port now
                o_cmd.seed_eval = 1'b1;
                if (!i_sts.seed_ok) begin
                    n_state = S_DONE;
                end else if (i_sts.epoch_full) begin
                    n_state = S_CLR;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.run_init = 1'b1;
                n_state        = S_POP;
            end
            S_POP: begin
                if (i_sts.q_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_CUR;
                end
            end
            S_CUR: begin
                o_cmd.cur_cap = 1'b1;
                n_state       = S_NREQ;
            end
            S_NREQ: begin
                if (i_sts.nbr_in) begin
                    n_state = S_NCHK;
                end else begin
                    o_cmd.nbr_skip = 1'b1;
                    if (i_sts.k_last) begin
                        n_state = S_POP;
                    end
                end
            end
            S_NCHK: begin
                o_cmd.nbr_chk = 1'b1;
                n_state       = i_sts.k_last ? S_POP : S_NREQ;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/ffbb_dp.sv =====
module ffbb_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffbb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    output ffbb_pkg::t_out_item o_out_data,
    input  logic                i_out_ready,
    input  logic                i_cfg_valid,
    input  ffbb_pkg::t_cfg_item i_cfg_data,
    output logic                o_cfg_ready,
    input  ffbb_pkg::t_cmd      i_cmd,
    output ffbb_pkg::t_sts      o_sts
);
    import ffbb_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    logic [CFG_W-1:0]   r_img_w, r_img_h;
    logic [CMP_W-1:0]   w_cfg, h_cfg, w_eff, h_eff;
    logic               in_in;
    logic [AW-1:0]      in_addr;
    logic               r_seed_in;
    logic [AW-1:0]      r_seed_addr;
    logic               r_hit;
    logic [EPOCH_W-1:0] r_epoch, epoch_new;
    logic [AW-1:0]      r_clr_cnt;
    logic [AW:0]        r_head, r_tail;
    logic [XW-1:0]      r_cur_x, r_lo_x, r_hi_x, nx, q_x;
    logic [YW-1:0]      r_cur_y, r_lo_y, r_hi_y, ny, q_y;
    logic [DIR_W-1:0]   r_k;
    logic               nbr_in;
    logic [AW-1:0]      nbr_addr;
    logic               fresh;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [CMP_W-1:0]   span_x, span_y;

    logic               opa_rd;
    logic [AW-1:0]      opa_rd_addr;
    logic               vis_wr_en;
    logic [AW-1:0]      vis_wr_addr;
    logic [EPOCH_W-1:0] vis_wr_data, vis_rd;
    logic [AW-1:0]      q_wr_addr, q_wr_data, q_rd;

    // Effective image size, saturated to the map size
    assign w_cfg = CMP_W'(r_img_w);
    assign h_cfg = CMP_W'(r_img_h);
    assign w_eff = (w_cfg > CMP_W'(MAX_WIDTH))  ? CMP_W'(MAX_WIDTH)  : w_cfg;
    assign h_eff = (h_cfg > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : h_cfg;

    // Input coordinate bound check and map address
    assign in_in = !i_in_data.coord_x[15] && !i_in_data.coord_y[15]
                && (CMP_W'(i_in_data.coord_x[14:0]) < w_eff)
                && (CMP_W'(i_in_data.coord_y[14:0]) < h_eff);
    assign in_addr = {i_in_data.coord_y[YW-1:0], i_in_data.coord_x[XW-1:0]};

    // Configuration writes, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_RESET;
            r_img_h <= IMG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_data.index)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data.value;
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data.value;
                default: ;
            endcase
        end
    end

    // New tag for a run; the all-ones tag forces a visited sweep first
    assign epoch_new = (&r_epoch) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);

    // Neighbor of the current cell in direction r_k
    always_comb begin
        nbr_in = 1'b0;
        nx     = r_cur_x;
        ny     = r_cur_y;
        case (r_k)
            DIR_UP: begin
                nbr_in = (r_cur_y != '0);
                ny     = r_cur_y - YW'(1);
            end
            DIR_DOWN: begin
                nbr_in = (CMP_W'(r_cur_y) + CMP_W'(1)) < h_eff;
                ny     = r_cur_y + YW'(1);
            end
            DIR_LEFT: begin
                nbr_in = (r_cur_x != '0);
                nx     = r_cur_x - XW'(1);
            end
            DIR_RIGHT: begin
                nbr_in = (CMP_W'(r_cur_x) + CMP_W'(1)) < w_eff;
                nx     = r_cur_x + XW'(1);
            end
            default: begin
                nbr_in = 1'b0;
            end
        endcase
    end
    assign nbr_addr = {ny, nx};
    assign fresh    = (vis_rd != r_epoch) && opa_rd;

    // Queue head entry split into coordinates
    assign q_x = q_rd[XW-1:0];
    assign q_y = q_rd[AW-1:XW];

    // Fill control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch   <= '1;
            r_head    <= '0;
            r_tail    <= '0;
            r_k       <= DIR_UP;
            r_clr_cnt <= '0;
            r_hit     <= 1'b0;
            r_seed_in <= 1'b0;
        end else begin
            if (i_cmd.seed_cap) begin
                r_seed_in <= in_in;
            end
            if (i_cmd.seed_eval) begin
                r_hit     <= r_seed_in && opa_rd;
                r_clr_cnt <= '0;
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.run_init) begin
                r_epoch <= epoch_new;
                r_head  <= '0;
                r_tail  <= (AW+1)'(1);
            end
            if (i_cmd.pop) begin
                r_head <= r_head + (AW+1)'(1);
            end
            if (i_cmd.cur_cap) begin
                r_k <= DIR_UP;
            end
            if (i_cmd.nbr_skip || i_cmd.nbr_chk) begin
                r_k <= r_k + DIR_W'(1);
            end
            if (i_cmd.nbr_chk && fresh) begin
                r_tail <= r_tail + (AW+1)'(1);
            end
        end
    end

    // Seed address, current cell and bounding box
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_cap) begin
            r_seed_addr <= in_addr;
        end
        if (i_cmd.run_init) begin
            r_lo_x <= r_seed_addr[XW-1:0];
            r_hi_x <= r_seed_addr[XW-1:0];
            r_lo_y <= r_seed_addr[AW-1:XW];
            r_hi_y <= r_seed_addr[AW-1:XW];
        end
        if (i_cmd.cur_cap) begin
            r_cur_x <= q_x;
            r_cur_y <= q_y;
            if (q_x < r_lo_x) r_lo_x <= q_x;
            if (q_x > r_hi_x) r_hi_x <= q_x;
            if (q_y < r_lo_y) r_lo_y <= q_y;
            if (q_y > r_hi_y) r_hi_y <= q_y;
        end
    end

    // Result register
    assign span_x = CMP_W'(r_hi_x) - CMP_W'(r_lo_x) + CMP_W'(1);
    assign span_y = CMP_W'(r_hi_y) - CMP_W'(r_lo_y) + CMP_W'(1);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out.found      <= r_hit;
            r_out.box_x      <= r_hit ? 8'(r_lo_x) : 8'd0;
            r_out.box_y      <= r_hit ? 8'(r_lo_y) : 8'd0;
            r_out.box_width  <= r_hit ? span_x[8:0] : 9'd0;
            r_out.box_height <= r_hit ? span_y[8:0] : 9'd0;
        end
    end
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Opacity map: written by loads, read for the seed or a neighbor
    assign opa_rd_addr = i_cmd.seed_cap ? in_addr : nbr_addr;
    ffbb_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_opa_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load_wr && in_in),
        .i_wr_addr (in_addr),
        .i_wr_data (i_in_data.opaque),
        .i_rd_addr (opa_rd_addr),
        .o_rd_data (opa_rd)
    );

    // Visited map: a cell is visited when its tag equals the run tag
    assign vis_wr_en   = i_cmd.clr_step || i_cmd.run_init || (i_cmd.nbr_chk && fresh);
    assign vis_wr_addr = i_cmd.clr_step ? r_clr_cnt :
                         i_cmd.run_init ? r_seed_addr : nbr_addr;
    assign vis_wr_data = i_cmd.clr_step ? '0 :
                         i_cmd.run_init ? epoch_new : r_epoch;
    ffbb_ram #(.WIDTH(EPOCH_W), .DEPTH(DEPTH)) u_vis_ram (
        .i_clk     (i_clk),
        .i_wr_en   (vis_wr_en),
        .i_wr_addr (vis_wr_addr),
        .i_wr_data (vis_wr_data),
        .i_rd_addr (nbr_addr),
        .o_rd_data (vis_rd)
    );

    // Pending queue of cell addresses
    assign q_wr_addr = i_cmd.run_init ? '0 : r_tail[AW-1:0];
    assign q_wr_data = i_cmd.run_init ? r_seed_addr : nbr_addr;
    ffbb_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.run_init || (i_cmd.nbr_chk && fresh)),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (q_wr_data),
        .i_rd_addr (r_head[AW-1:0]),
        .o_rd_data (q_rd)
    );

    // Status to the controller
    assign o_sts.seed_ok    = r_seed_in && opa_rd;
    assign o_sts.epoch_full = &r_epoch;
    assign o_sts.clr_last   = &r_clr_cnt;
    assign o_sts.q_empty    = (r_head == r_tail);
    assign o_sts.nbr_in     = nbr_in;
    assign o_sts.k_last     = (r_k == DIR_RIGHT);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
endmodule
